/* design/assert_macros.svh */
// Assertion helper macros shared by the blitter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/spb_pkg.sv */
// Shared constants and types of the sprite pixel blitter.
`timescale 1ns / 1ps

package spb_pkg;

    // Frame geometry defaults
    localparam int FB_WIDTH_DEF  = 256;
    localparam int FB_HEIGHT_DEF = 256;

    // Pixel and channel widths
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = CHAN_W + 1;
    localparam int DIV_W   = 8;
    localparam int NUM_CH  = 3;

    // Item op codes
    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_FILL = 2'd2;

    // Blit modes
    localparam logic [1:0] MODE_OPAQUE = 2'd0;
    localparam logic [1:0] MODE_CHROMA = 2'd1;
    localparam logic [1:0] MODE_SUBST  = 2'd2;
    localparam logic [1:0] MODE_GHOST  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_BLIT_MODE   = 3'd0;
    localparam logic [2:0] REG_CHROMA      = 3'd1;
    localparam logic [2:0] REG_SUBST       = 3'd2;
    localparam logic [2:0] REG_GHOST_DIV   = 3'd3;
    localparam logic [2:0] REG_CLIP_LEFT   = 3'd4;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd5;
    localparam logic [2:0] REG_CLIP_RIGHT  = 3'd6;
    localparam logic [2:0] REG_CLIP_BOTTOM = 3'd7;

    // Configuration reset values
    localparam logic [23:0] CHROMA_RST    = 24'hFF00FF;
    localparam logic [7:0]  GHOST_DIV_RST = 8'd32;
    localparam logic [8:0]  CLIP_FAR_RST  = 9'd256;

    // Ghost divider request and response
    typedef struct packed {
        logic                         start;
        logic [NUM_CH-1:0][SUM_W-1:0] sum;
        logic [DIV_W-1:0]             divisor;
    } ghost_req_t;

    typedef struct packed {
        logic               done;
        logic [COLOR_W-1:0] color;
    } ghost_rsp_t;

endpackage

/* design/sprite_pixel_blitter.sv */
// Top level of the sprite pixel blitter: control, clipping and framebuffer access.
// Each item passes S_EXEC; a read in frame then S_READ_WAIT, a ghost blend draw S_GHOST_RD and
// S_GHOST_WAIT (8-step divider), a fill S_FILL. A read result strobes for one cycle, registered
// from S_READ_WAIT (from S_EXEC when the read lies off frame); the next item can be taken at the
// edge ending it. After reset the frame is swept to black, one pixel a cycle, with busy high;
// configuration writes are taken throughout. The receiver cannot stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sprite_pixel_blitter
    import spb_pkg::*;
#(
    parameter int FB_WIDTH  = FB_WIDTH_DEF,
    parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [11:0]        dst_x,
    input  logic [11:0]        dst_y,
    input  logic [COLOR_W-1:0] src_color,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [COLOR_W-1:0] cfg_data,
    output logic               result_strobe,
    output logic [COLOR_W-1:0] pixel_color,
    output logic               out_of_frame
);

    localparam int PIX_COUNT = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W    = $clog2(PIX_COUNT);
    localparam int PROD_W    = ADDR_W + 12;
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(PIX_COUNT - 1);
    localparam logic signed [12:0] FB_W_S    = 13'(FB_WIDTH);
    localparam logic signed [12:0] FB_H_S    = 13'(FB_HEIGHT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_READ_WAIT,
        S_GHOST_RD,
        S_GHOST_WAIT
    } state_t;

    // Configuration registers
    logic [1:0]         blit_mode_reg;
    logic [COLOR_W-1:0] chroma_reg;
    logic [COLOR_W-1:0] subst_reg;
    logic [DIV_W-1:0]   ghost_div_reg;
    logic [8:0]         clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;

    // Control and item registers
    state_t             state_reg;
    logic [ADDR_W-1:0]  fill_idx_reg;
    logic [COLOR_W-1:0] fill_color_reg;
    logic [1:0]         op_reg;
    logic [11:0]        x_reg, y_reg;
    logic [COLOR_W-1:0] src_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               strobe_reg;
    logic [COLOR_W-1:0] pixel_reg;
    logic               oof_reg;

    // Decode of the held item
    logic signed [12:0] xs, ys;
    logic               frame_ok, clip_ok, key_hit, fill_last;
    logic [PROD_W-1:0]  lin_addr;
    logic [ADDR_W-1:0]  addr_calc;
    logic               read_done;

    // Framebuffer port
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [COLOR_W-1:0] ram_wdata, ram_rdata;
    logic               draw_we;
    logic [COLOR_W-1:0] draw_color;
    logic               draw_ghost;

    ghost_req_t ghost_req;
    ghost_rsp_t ghost_rsp;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blit_mode_reg   <= MODE_OPAQUE;
            chroma_reg      <= CHROMA_RST;
            subst_reg       <= '0;
            ghost_div_reg   <= GHOST_DIV_RST;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= CLIP_FAR_RST;
            clip_bottom_reg <= CLIP_FAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLIT_MODE:   blit_mode_reg   <= cfg_data[1:0];
                REG_CHROMA:      chroma_reg      <= cfg_data;
                REG_SUBST:       subst_reg       <= cfg_data;
                REG_GHOST_DIV:   ghost_div_reg   <= cfg_data[DIV_W-1:0];
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_data[8:0];
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data[8:0];
                REG_CLIP_RIGHT:  clip_right_reg  <= cfg_data[8:0];
                REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data[8:0];
                default:         ;
            endcase
        end
    end

    // Coordinate checks and linear address
    assign xs       = $signed({x_reg[11], x_reg});
    assign ys       = $signed({y_reg[11], y_reg});
    assign frame_ok = (xs >= 13'sd0) && (ys >= 13'sd0) && (xs < FB_W_S) && (ys < FB_H_S);
    assign clip_ok  = (xs >= $signed({4'b0, clip_left_reg}))
                   && (xs <  $signed({4'b0, clip_right_reg}))
                   && (ys >= $signed({4'b0, clip_top_reg}))
                   && (ys <  $signed({4'b0, clip_bottom_reg}));
    assign key_hit  = (src_reg == chroma_reg);
    assign lin_addr = PROD_W'(y_reg[10:0]) * PROD_W'(FB_WIDTH) + PROD_W'(x_reg[10:0]);
    assign addr_calc = lin_addr[ADDR_W-1:0];
    assign fill_last = (fill_idx_reg == LAST_ADDR);

    // A read result is ready after the framebuffer read, or at once when off frame
    assign read_done = (state_reg == S_READ_WAIT)
                    || ((state_reg == S_EXEC) && (op_reg == OP_READ) && !frame_ok);

    // Draw decision by blit mode
    always_comb
    begin
        draw_we    = 1'b0;
        draw_ghost = 1'b0;
        draw_color = src_reg;
        if (op_reg == OP_DRAW && frame_ok && clip_ok)
        begin
            case (blit_mode_reg)
                MODE_OPAQUE: draw_we = 1'b1;
                MODE_CHROMA: draw_we = !key_hit;
                MODE_SUBST:
                begin
                    draw_we    = !key_hit;
                    draw_color = subst_reg;
                end
                MODE_GHOST:  draw_ghost = !key_hit;
                default:     ;
            endcase
        end
    end

    // Framebuffer access per state
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = draw_color;
        case (state_reg)
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_addr  = fill_idx_reg;
                ram_wdata = fill_color_reg;
            end
            S_EXEC:
            begin
                ram_we   = draw_we;
                ram_addr = addr_calc;
            end
            S_GHOST_WAIT:
            begin
                ram_we    = ghost_rsp.done;
                ram_wdata = ghost_rsp.color;
            end
            default: ;
        endcase
    end

    // Channel sums go to the divider once the destination pixel is back
    always_comb
    begin
        ghost_req.start   = (state_reg == S_GHOST_RD);
        ghost_req.divisor = ghost_div_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            ghost_req.sum[c] = SUM_W'(ram_rdata[c*CHAN_W +: CHAN_W])
                             + SUM_W'(src_reg[c*CHAN_W +: CHAN_W]);
        end
    end

    // Sequencer; reset starts a black fill of the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            fill_idx_reg   <= '0;
            fill_color_reg <= '0;
            strobe_reg     <= 1'b0;
            pixel_reg      <= '0;
            oof_reg        <= 1'b0;
        end
        else
        begin
            strobe_reg <= read_done;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= op;
                        x_reg     <= dst_x;
                        y_reg     <= dst_y;
                        src_reg   <= src_color;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    addr_reg <= addr_calc;
                    case (op_reg)
                        OP_READ:
                        begin
                            if (frame_ok)
                            begin
                                state_reg <= S_READ_WAIT;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                                pixel_reg <= '0;
                                oof_reg   <= 1'b1;
                            end
                        end
                        OP_FILL:
                        begin
                            fill_color_reg <= src_reg;
                            fill_idx_reg   <= '0;
                            state_reg      <= S_FILL;
                        end
                        OP_DRAW:
                        begin
                            state_reg <= draw_ghost ? S_GHOST_RD : S_IDLE;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_FILL:
                begin
                    fill_idx_reg <= fill_last ? '0 : fill_idx_reg + ADDR_W'(1);
                    if (fill_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_READ_WAIT:
                begin
                    pixel_reg <= ram_rdata;
                    oof_reg   <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_GHOST_RD:
                begin
                    state_reg <= S_GHOST_WAIT;
                end
                S_GHOST_WAIT:
                begin
                    if (ghost_rsp.done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign pixel_color   = pixel_reg;
    assign out_of_frame  = oof_reg;

    spb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIX_COUNT)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    spb_ghost_div u_ghost_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ghost_req),
        .rsp   (ghost_rsp)
    );

    `ASSERT_NEXT(a_strobe_single, clk, rst_n, strobe_reg, !strobe_reg,
        "result strobe held more than one cycle")
    `ASSERT_IMPLIES(a_oof_black, clk, rst_n, strobe_reg && oof_reg, pixel_reg == '0,
        "out-of-frame read returned a nonzero color")
    `ASSERT_NEXT(a_fill_wraps, clk, rst_n, (state_reg == S_FILL) && fill_last,
        (state_reg == S_IDLE) && (fill_idx_reg == '0), "fill sweep did not end cleanly")
    `ASSERT_IMPLIES(a_ghost_wait_only, clk, rst_n, ghost_rsp.done,
        state_reg == S_GHOST_WAIT, "ghost result arrived outside the blend wait")

endmodule

/* design/spb_ram.sv */
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module spb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/spb_ghost_div.sv */
// Three-lane restoring divider for the ghost blend, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spb_ghost_div
    import spb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ghost_req_t req,
    output ghost_rsp_t rsp
);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [CHAN_W-1:0] rem_reg  [NUM_CH];
    logic [CHAN_W-1:0] rem_next [NUM_CH];
    logic [CHAN_W-1:0] low_reg  [NUM_CH];
    logic [CHAN_W-1:0] low_next [NUM_CH];
    logic [CHAN_W-1:0] quo_reg  [NUM_CH];
    logic [CHAN_W-1:0] quo_next [NUM_CH];
    logic              sat_reg  [NUM_CH];
    logic              sat_next [NUM_CH];

    // Dividend is sum*16; quotient saturates when its upper bits reach the divisor
    always_comb
    begin
        logic [CHAN_W:0] trial;
        trial       = '0;
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        div_next    = div_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            rem_next[c] = rem_reg[c];
            low_next[c] = low_reg[c];
            quo_next[c] = quo_reg[c];
            sat_next[c] = sat_reg[c];
        end
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            div_next    = req.divisor;
            for (int c = 0; c < NUM_CH; c++)
            begin
                rem_next[c] = CHAN_W'(req.sum[c][SUM_W-1:4]);
                low_next[c] = {req.sum[c][3:0], 4'b0000};
                quo_next[c] = '0;
                sat_next[c] = CHAN_W'(req.sum[c][SUM_W-1:4]) >= req.divisor;
            end
        end
        else if (active_reg)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                trial = {rem_reg[c], low_reg[c][CHAN_W-1]};
                if (trial >= {1'b0, div_reg})
                begin
                    trial       = trial - {1'b0, div_reg};
                    quo_next[c] = {quo_reg[c][CHAN_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next[c] = {quo_reg[c][CHAN_W-2:0], 1'b0};
                end
                rem_next[c] = trial[CHAN_W-1:0];
                low_next[c] = {low_reg[c][CHAN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        for (int c = 0; c < NUM_CH; c++)
        begin
            rem_reg[c] <= rem_next[c];
            low_reg[c] <= low_next[c];
            quo_reg[c] <= quo_next[c];
            sat_reg[c] <= sat_next[c];
        end
    end

    // Saturated channels read as full scale
    always_comb
    begin
        rsp.done = done_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            rsp.color[c*CHAN_W +: CHAN_W] = sat_reg[c] ? '1 : quo_reg[c];
        end
    end

    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg,
        "ghost divider done held more than one cycle")
    `ASSERT_IMPLIES(a_no_restart, clk, rst_n, req.start, !active_reg,
        "ghost divider started while busy")

endmodule
